@@ rtl/ssq_pkg.sv @@
// ----------------------------------------------------------------------------
// ssq_pkg
// Shared types and constants of the stable sorted priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package ssq_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int CMD_W        = 2;
  localparam int STAT_W       = 2;
  localparam int PRIO_W       = 16;
  localparam int DATA_W       = 32;
  localparam int GATHER_W     = 2 * DATA_W;

  localparam logic signed [PRIO_W-1:0] PRIO_MIN = {1'b1, {(PRIO_W-1){1'b0}}};

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_CUT_IN = 2'd2
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    OP_HOLD  = 2'd0,
    OP_PLACE = 2'd1,
    OP_POP   = 2'd2
  } cell_op_e;

  typedef struct packed {
    cell_op_e                  op;
    logic signed [PRIO_W-1:0]  prio;
    logic        [DATA_W-1:0]  data;
  } cell_ctl_t;

endpackage

`default_nettype wire

@@ rtl/stable_sorted_priority_queue_unit.sv @@
// ----------------------------------------------------------------------------
// stable_sorted_priority_queue_unit
// Sorted priority queue with arrival order kept among equal priorities.
// ----------------------------------------------------------------------------
//
//   channel   handshake          payload
//   command   start / busy       command_i, priority_req_i, payload_i
//   result    done_o strobe      status_o, popped_data_o, entry_total_o,
//                                is_empty_o, middle_data_o, last_data_o
//
// a command updates the whole cell chain at the edge that accepts it
// the result strobe rises once the registered gather tree has carried the
// cell contents to its root; busy is low in the strobe cycle, so the next
// command can be accepted in that cycle, but not before the result is out
// reset empties the queue at once; slot contents are left as they are
// the receiver cannot stall: done_o is high for exactly one cycle
// ----------------------------------------------------------------------------
`default_nettype none

module stable_sorted_priority_queue_unit #(
  parameter int CAPACITY = ssq_pkg::CAPACITY_DEF,
  localparam int CntW    = $clog2(CAPACITY + 1)
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic        [ssq_pkg::CMD_W-1:0]    command_i,
  input  wire logic signed [ssq_pkg::PRIO_W-1:0]   priority_req_i,
  input  wire logic signed [ssq_pkg::DATA_W-1:0]   payload_i,
  output logic                                     done_o,
  output logic             [ssq_pkg::STAT_W-1:0]   status_o,
  output logic signed      [ssq_pkg::DATA_W-1:0]   popped_data_o,
  output logic             [CntW-1:0]              entry_total_o,
  output logic                                     is_empty_o,
  output logic signed      [ssq_pkg::DATA_W-1:0]   middle_data_o,
  output logic signed      [ssq_pkg::DATA_W-1:0]   last_data_o
);

  localparam int Latency = $clog2(CAPACITY) + 2;
  localparam int TimW    = $clog2(Latency + 1);
  localparam logic [CntW-1:0] Full = CntW'(CAPACITY);

  logic                  accept;
  logic [CntW-1:0]       count_q, count_d;
  logic [TimW-1:0]       tim_q, tim_d;
  ssq_pkg::status_e      status_q, status_d;
  logic [ssq_pkg::DATA_W-1:0] popped_q, popped_d;
  ssq_pkg::cell_ctl_t    ctl;
  logic signed [ssq_pkg::PRIO_W-1:0] cut_prio;

  logic                               stay  [CAPACITY];
  logic signed [ssq_pkg::PRIO_W-1:0]  prio  [CAPACITY];
  logic        [ssq_pkg::DATA_W-1:0]  data  [CAPACITY];
  logic [CAPACITY-1:0][ssq_pkg::GATHER_W-1:0] leaf;
  logic [ssq_pkg::GATHER_W-1:0]       root;

  assign busy   = tim_q > TimW'(1);
  assign accept = start && !busy;

  assign cut_prio = (prio[0] == ssq_pkg::PRIO_MIN) ? prio[0] : prio[0] - 16'sd1;

  always_comb begin
    count_d  = count_q;
    status_d = status_q;
    popped_d = popped_q;
    ctl.op   = ssq_pkg::OP_HOLD;
    ctl.prio = priority_req_i;
    ctl.data = payload_i;
    if (accept) begin
      status_d = ssq_pkg::STAT_OK;
      popped_d = '0;
      unique case (command_i)
        ssq_pkg::CMD_INSERT: begin
          if (count_q == Full) begin
            status_d = ssq_pkg::STAT_FULL;
          end else begin
            ctl.op  = ssq_pkg::OP_PLACE;
            count_d = count_q + CntW'(1);
          end
        end
        ssq_pkg::CMD_REMOVE: begin
          if (count_q == '0) begin
            status_d = ssq_pkg::STAT_EMPTY;
          end else begin
            ctl.op   = ssq_pkg::OP_POP;
            popped_d = data[0];
            count_d  = count_q - CntW'(1);
          end
        end
        ssq_pkg::CMD_CUT_IN: begin
          ctl.prio = cut_prio;
          if (count_q == '0) begin
            status_d = ssq_pkg::STAT_EMPTY;
          end else if (count_q == Full) begin
            status_d = ssq_pkg::STAT_FULL;
          end else begin
            ctl.op  = ssq_pkg::OP_PLACE;
            count_d = count_q + CntW'(1);
          end
        end
        default: begin
          status_d = ssq_pkg::STAT_OK;
        end
      endcase
    end
  end

  always_comb begin
    tim_d = tim_q;
    if (accept) begin
      tim_d = TimW'(Latency);
    end else if (tim_q != '0) begin
      tim_d = tim_q - TimW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      tim_q   <= '0;
    end else begin
      count_q <= count_d;
      tim_q   <= tim_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    popped_q <= popped_d;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [CntW-1:0] Idx     = CntW'(i);
    localparam logic [CntW-1:0] IdxNext = CntW'(i + 1);
    localparam int Left  = (i == 0) ? 0 : i - 1;
    localparam int Right = (i == CAPACITY - 1) ? i : i + 1;

    logic is_mid, is_last;

    assign is_mid  = (count_q != '0) && ((count_q >> 1) == Idx);
    assign is_last = (count_q == IdxNext);
    assign leaf[i] = {is_mid ? data[i] : {ssq_pkg::DATA_W{1'b0}},
                      is_last ? data[i] : {ssq_pkg::DATA_W{1'b0}}};

    ssq_cell u_cell (
      .clk_i        (clk_i),
      .ctl_i        (ctl),
      .occ_i        (count_q > Idx),
      .left_stay_i  ((i == 0) ? 1'b1 : stay[Left]),
      .left_prio_i  (prio[Left]),
      .left_data_i  (data[Left]),
      .right_prio_i (prio[Right]),
      .right_data_i (data[Right]),
      .stay_o       (stay[i]),
      .prio_o       (prio[i]),
      .data_o       (data[i])
    );
  end

  ssq_gather #(
    .CAPACITY (CAPACITY)
  ) u_gather (
    .clk_i  (clk_i),
    .leaf_i (leaf),
    .root_o (root)
  );

  assign done_o        = tim_q == TimW'(1);
  assign status_o      = status_q;
  assign popped_data_o = popped_q;
  assign entry_total_o = count_q;
  assign is_empty_o    = count_q == '0;
  assign middle_data_o = root[ssq_pkg::GATHER_W-1:ssq_pkg::DATA_W];
  assign last_data_o   = root[ssq_pkg::DATA_W-1:0];

endmodule

`default_nettype wire

@@ rtl/ssq_cell.sv @@
// ----------------------------------------------------------------------------
// ssq_cell
// One slot of the sorted chain: keeps, takes the new entry or takes a neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module ssq_cell (
  input  wire logic                                clk_i,
  input  wire ssq_pkg::cell_ctl_t                  ctl_i,
  input  wire logic                                occ_i,
  input  wire logic                                left_stay_i,
  input  wire logic signed [ssq_pkg::PRIO_W-1:0]   left_prio_i,
  input  wire logic        [ssq_pkg::DATA_W-1:0]   left_data_i,
  input  wire logic signed [ssq_pkg::PRIO_W-1:0]   right_prio_i,
  input  wire logic        [ssq_pkg::DATA_W-1:0]   right_data_i,
  output logic                                     stay_o,
  output logic signed [ssq_pkg::PRIO_W-1:0]        prio_o,
  output logic        [ssq_pkg::DATA_W-1:0]        data_o
);

  logic signed [ssq_pkg::PRIO_W-1:0] prio_q, prio_d;
  logic        [ssq_pkg::DATA_W-1:0] data_q, data_d;

  assign stay_o = occ_i && (prio_q <= ctl_i.prio);

  always_comb begin
    prio_d = prio_q;
    data_d = data_q;
    unique case (ctl_i.op)
      ssq_pkg::OP_PLACE: begin
        if (!stay_o) begin
          if (left_stay_i) begin
            prio_d = ctl_i.prio;
            data_d = ctl_i.data;
          end else begin
            prio_d = left_prio_i;
            data_d = left_data_i;
          end
        end
      end
      ssq_pkg::OP_POP: begin
        prio_d = right_prio_i;
        data_d = right_data_i;
      end
      default: begin
        prio_d = prio_q;
        data_d = data_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    prio_q <= prio_d;
    data_q <= data_d;
  end

  assign prio_o = prio_q;
  assign data_o = data_q;

endmodule

`default_nettype wire

@@ rtl/ssq_gather.sv @@
// ----------------------------------------------------------------------------
// ssq_gather
// Registered OR tree that collects the masked middle and last slot data.
// ----------------------------------------------------------------------------
`default_nettype none

module ssq_gather #(
  parameter int CAPACITY = ssq_pkg::CAPACITY_DEF
) (
  input  wire logic                                       clk_i,
  input  wire logic [CAPACITY-1:0][ssq_pkg::GATHER_W-1:0] leaf_i,
  output logic      [ssq_pkg::GATHER_W-1:0]               root_o
);

  localparam int Levels = $clog2(CAPACITY);
  localparam int Leaves = 1 << Levels;

  logic [ssq_pkg::GATHER_W-1:0] node_q [1:2*Leaves-1];

  for (genvar k = 0; k < Leaves; k++) begin : g_leaf
    if (k < CAPACITY) begin : g_used
      always_ff @(posedge clk_i) begin
        node_q[Leaves+k] <= leaf_i[k];
      end
    end else begin : g_pad
      always_ff @(posedge clk_i) begin
        node_q[Leaves+k] <= '0;
      end
    end
  end

  for (genvar n = 1; n < Leaves; n++) begin : g_node
    always_ff @(posedge clk_i) begin
      node_q[n] <= node_q[2*n] | node_q[2*n+1];
    end
  end

  assign root_o = node_q[1];

endmodule

`default_nettype wire

@@ rtl/ssq_checker.sv @@
// ----------------------------------------------------------------------------
// ssq_checker
// Port-level checks of the priority queue, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ssq_checker #(
  parameter int CAPACITY = ssq_pkg::CAPACITY_DEF,
  localparam int CntW    = $clog2(CAPACITY + 1)
) (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              start,
  input wire logic                              busy,
  input wire logic                              done_o,
  input wire logic [ssq_pkg::STAT_W-1:0]        status_o,
  input wire logic [CntW-1:0]                   entry_total_o,
  input wire logic                              is_empty_o
);

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("busy not raised after an accepted item");

  a_strobe_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("busy during result strobe");

  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (is_empty_o == (entry_total_o == '0)))
    else $error("empty flag disagrees with count");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o == ssq_pkg::STAT_FULL) |-> (entry_total_o == CntW'(CAPACITY)))
    else $error("full status with queue not full");

endmodule

bind stable_sorted_priority_queue_unit ssq_checker #(.CAPACITY(CAPACITY)) u_ssq_checker (.*);

`default_nettype wire
